// ----- sv/sbiir_pkg.sv -----
package sbiir_pkg;

  localparam int NUM_TAPS_DEF  = 16;
  localparam int DEN_TAPS_DEF  = 16;
  localparam int MAX_DELAY_DEF = 16;

  localparam int SMP_W      = 32;
  localparam int COEF_W     = 24;
  localparam int PROD_W     = SMP_W + COEF_W;
  localparam int HP_W       = 16;
  localparam int DLY_W      = 5;
  localparam int PH_W       = 17;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 16;
  localparam int FRAC_SHIFT = 20;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 1'b0,
    REG_INPUT_DELAY = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic neg;
  } mac_ctl_t;

endpackage

// ----- sv/sbiir_mac.sv -----
module sbiir_mac import sbiir_pkg::*; #(
  parameter int ACC_W = PROD_W + 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [SMP_W-1:0]  smp,
  input  logic signed [COEF_W-1:0] coef,
  output logic                     busy,
  output logic signed [SMP_W-1:0]  y,
  output logic                     sat
);

  localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W+1)'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [ACC_W:0] Q_MAX =
    {{(ACC_W+1-SMP_W){1'b0}}, 1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] Q_MIN = ~Q_MAX;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;
  logic                     prod_neg;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    rnd;
  logic signed [ACC_W:0]    q;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= smp * coef;
    prod_neg <= ctl.neg;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      if (prod_neg) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // round half up to q16.16, then clip
  always_comb begin
    rnd = (ACC_W+1)'(acc) + RND_BIAS;
    q   = rnd >>> FRAC_SHIFT;
    sat = 1'b0;
    y   = q[SMP_W-1:0];
    if (q > Q_MAX) begin
      y   = Q_MAX[SMP_W-1:0];
      sat = 1'b1;
    end else if (q < Q_MIN) begin
      y   = Q_MIN[SMP_W-1:0];
      sat = 1'b1;
    end
  end

  assign busy = prod_v;

endmodule

// ----- sv/switched_bank_iir_filter_unit.sv -----
// channel  handshake           payload
// cfg      cfg_we              cfg_index, cfg_data
// in       in_valid/in_stall   cmd, sample_in, coef_bank, coef_kind, coef_index, coef_value
// out      out_valid/out_stall y_out, bank_used, saturated
//
// a filter transfer stalls the input through the tap walk and the drain:
// one shared multiply-accumulate walks one tap per cycle over the memories
// coefficient writes, clears and unused commands do not stall the input
// reset clears all per-entry valid bits at once, clear only the history ones; no clearing pass
// results sit in an output register; a new item is taken while one waits, and a
// filter result only finishes once that register is free
module switched_bank_iir_filter_unit import sbiir_pkg::*; #(
  parameter int NUM_TAPS  = NUM_TAPS_DEF,
  parameter int DEN_TAPS  = DEN_TAPS_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [SMP_W-1:0]  sample_in,
  input  logic                     coef_bank,
  input  logic                     coef_kind,
  input  logic [IDX_W-1:0]         coef_index,
  input  logic signed [COEF_W-1:0] coef_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SMP_W-1:0]  y_out,
  output logic                     bank_used,
  output logic                     saturated
);

  localparam int UL    = NUM_TAPS + MAX_DELAY;
  localparam int UA_W  = (UL > 1) ? $clog2(UL) : 1;
  localparam int YA_W  = (DEN_TAPS > 1) ? $clog2(DEN_TAPS) : 1;
  localparam int HD    = UL + DEN_TAPS;
  localparam int HA_W  = $clog2(HD);
  localparam int TT    = NUM_TAPS + DEN_TAPS;
  localparam int CD    = 2 * TT;
  localparam int CA_W  = $clog2(CD);
  localparam int ST_W  = $clog2(TT);
  localparam int ACC_W = PROD_W + $clog2(TT) + 1;

  // history memory: input ring at 0..UL-1, output ring above it
  logic signed [SMP_W-1:0]  hist_mem [HD];
  logic [HD-1:0]            hist_vld;
  // coefficient memory: numerator banks, then denominator banks
  logic signed [COEF_W-1:0] coef_mem [CD];
  logic [CD-1:0]            coef_vld;

  logic [HP_W-1:0]  half_period;
  logic [DLY_W-1:0] in_delay;
  logic [PH_W-1:0]  phase;
  logic [UA_W-1:0]  u_wp;
  logic [YA_W-1:0]  y_wp;
  state_t           state, state_next;
  logic [ST_W-1:0]  step;
  logic [UA_W-1:0]  u_ra;
  logic [YA_W-1:0]  y_ra;
  logic [CA_W-1:0]  c_ra;
  logic             bank;

  logic signed [SMP_W-1:0]  h_q;
  logic signed [COEF_W-1:0] c_q;
  logic                     hv_q;
  logic                     cv_q;
  logic                     rd_v;
  logic                     rd_neg;

  logic                    accept;
  logic                    do_filter;
  logic                    do_coef;
  logic                    do_clear;
  logic [UA_W-1:0]         u_wp_next;
  logic [YA_W-1:0]         y_wp_next;
  logic [UA_W:0]           dly_c;
  logic [UA_W:0]           u_sum;
  logic [UA_W-1:0]         u_start;
  logic [PH_W:0]           ph_inc;
  logic [PH_W:0]           two_hp;
  logic [PH_W-1:0]         phase_next;
  logic                    bank_next;
  logic                    coef_ok;
  logic [CA_W-1:0]         cw_addr;
  logic [CA_W-1:0]         den_base;
  logic                    is_den;
  logic [HA_W-1:0]         h_addr;
  logic [HA_W-1:0]         y_addr;
  logic                    fin;
  mac_ctl_t                mac_ctl;
  logic signed [SMP_W-1:0]  mac_smp;
  logic signed [COEF_W-1:0] mac_coef;
  logic                    mac_busy;
  logic signed [SMP_W-1:0]  mac_y;
  logic                    mac_sat;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign do_filter = accept && (cmd == CMD_FILTER);
  assign do_coef   = accept && (cmd == CMD_COEF);
  assign do_clear  = accept && (cmd == CMD_CLEAR);

  always_comb begin
    u_wp_next = (u_wp == '0) ? UA_W'(UL - 1) : u_wp - 1'b1;
    y_wp_next = (y_wp == '0) ? YA_W'(DEN_TAPS - 1) : y_wp - 1'b1;
    dly_c     = (in_delay > MAX_DELAY) ? (UA_W+1)'(MAX_DELAY) : (UA_W+1)'(in_delay);
    u_sum     = {1'b0, u_wp_next} + dly_c;
    u_start   = (u_sum >= (UA_W+1)'(UL)) ? UA_W'(u_sum - (UA_W+1)'(UL)) : u_sum[UA_W-1:0];
  end

  // phase wraps at twice the half period; zero half period pins bank zero
  always_comb begin
    ph_inc = {1'b0, phase} + (PH_W+1)'(1);
    two_hp = {1'b0, half_period, 1'b0};
    if (half_period == '0 || ph_inc >= two_hp) begin
      phase_next = '0;
    end else begin
      phase_next = ph_inc[PH_W-1:0];
    end
    bank_next = (half_period != '0) && !(phase_next < {1'b0, half_period});
  end

  always_comb begin
    if (coef_kind) begin
      coef_ok = (coef_index < DEN_TAPS);
      cw_addr = CA_W'(2 * NUM_TAPS) + (coef_bank ? CA_W'(DEN_TAPS) : '0)
                + CA_W'(coef_index);
    end else begin
      coef_ok = (coef_index < NUM_TAPS);
      cw_addr = (coef_bank ? CA_W'(NUM_TAPS) : '0) + CA_W'(coef_index);
    end
  end

  assign den_base = CA_W'(2 * NUM_TAPS) + (bank ? CA_W'(DEN_TAPS) : '0);
  assign is_den   = (step >= ST_W'(NUM_TAPS));
  assign h_addr   = is_den ? HA_W'(UL) + HA_W'(y_ra) : HA_W'(u_ra);
  assign y_addr   = HA_W'(UL) + HA_W'(y_wp_next);
  assign fin      = (state == S_DRAIN) && !rd_v && !mac_busy && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (do_filter) state_next = S_RUN;
      end
      S_RUN: begin
        if (step == ST_W'(TT - 1)) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (fin) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= '0;
      in_delay    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HALF_PERIOD: half_period <= cfg_data;
        REG_INPUT_DELAY: in_delay    <= cfg_data[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      u_wp     <= '0;
      y_wp     <= '0;
      hist_vld <= '0;
      coef_vld <= '0;
      rd_v     <= 1'b0;
    end else begin
      rd_v <= (state == S_RUN);
      if (do_filter) begin
        phase          <= phase_next;
        u_wp           <= u_wp_next;
        hist_vld[HA_W'(u_wp_next)] <= 1'b1;
      end
      if (do_clear) begin
        hist_vld <= '0;
      end
      if (do_coef && coef_ok) begin
        coef_vld[cw_addr] <= 1'b1;
      end
      if (fin) begin
        y_wp             <= y_wp_next;
        hist_vld[y_addr] <= 1'b1;
      end
    end
  end

  // tap walk: numerator over the input ring from the delay, then the output ring
  always_ff @(posedge clk) begin
    if (do_filter) begin
      bank <= bank_next;
      step <= '0;
      u_ra <= u_start;
      y_ra <= y_wp;
      c_ra <= bank_next ? CA_W'(NUM_TAPS) : '0;
    end else if (state == S_RUN) begin
      step <= step + 1'b1;
      if (is_den) begin
        y_ra <= (y_ra == YA_W'(DEN_TAPS - 1)) ? '0 : y_ra + 1'b1;
        c_ra <= c_ra + 1'b1;
      end else begin
        u_ra <= (u_ra == UA_W'(UL - 1)) ? '0 : u_ra + 1'b1;
        c_ra <= (step == ST_W'(NUM_TAPS - 1)) ? den_base : c_ra + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_filter) begin
      hist_mem[HA_W'(u_wp_next)] <= sample_in;
    end else if (fin) begin
      hist_mem[y_addr] <= mac_y;
    end
    if (do_coef && coef_ok) begin
      coef_mem[cw_addr] <= coef_value;
    end
    if (state == S_RUN) begin
      h_q    <= hist_mem[h_addr];
      c_q    <= coef_mem[c_ra];
      hv_q   <= hist_vld[h_addr];
      cv_q   <= coef_vld[c_ra];
      rd_neg <= is_den;
    end
  end

  // history entries never written since reset or clear, and coefficient entries never written since reset, read as zero
  assign mac_smp  = hv_q ? h_q : '0;
  assign mac_coef = cv_q ? c_q : '0;

  always_comb begin
    mac_ctl.clear = do_filter;
    mac_ctl.valid = rd_v;
    mac_ctl.neg   = rd_neg;
  end

  sbiir_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .smp (mac_smp),
    .coef(mac_coef),
    .busy(mac_busy),
    .y   (mac_y),
    .sat (mac_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      y_out     <= mac_y;
      bank_used <= bank;
      saturated <= mac_sat;
    end
  end

endmodule

// ----- sv/sbiir_checker.sv -----
module sbiir_checker import sbiir_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [CMD_W-1:0]         cmd,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [SMP_W-1:0]  y_out,
  input logic                     saturated
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // a filter transfer keeps the block busy for its tap walk
  a_busy_after_filter: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (cmd == CMD_FILTER) |=> in_stall)
    else $error("input not stalled after filter transfer");

  // commands other than filter never produce a result
  a_no_result_other: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (cmd != CMD_FILTER) && !out_valid |=> !out_valid)
    else $error("result after non-filter command");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (y_out == 32'sh7fffffff || y_out == 32'sh80000000))
    else $error("saturated flag with unclipped value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(y_out))
    else $error("stalled result changed");

endmodule

bind switched_bank_iir_filter_unit sbiir_checker u_sbiir_checker (.*);
